[rtl/core/sbo_pkg.sv]
// Shared widths, register codes and beat types for the segment/box overlap test.
// No dependencies; every other file in rtl/core imports this package.
package sbo_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int REACH_BITS  = 16;
   localparam int REACH_W     = REACH_BITS + 1;
   localparam int EPS_W       = 16;
   localparam int NUM_AXES    = 3;

   // Working widths, all exact: nothing below ever wraps.
   localparam int DIFF_W = COORD_WIDTH + 1;          // far - start
   localparam int PROD_W = DIFF_W + REACH_W;         // reach * (far - start)
   localparam int D_W    = PROD_W - REACH_BITS;      // shortened direction
   localparam int M_W    = COORD_WIDTH + 4;          // doubled midpoint offset
   localparam int CMP_W  = M_W + 1;                  // face-axis compare
   localparam int AD_W   = D_W + 1;                  // |d| + epsilon
   localparam int OPA_W  = M_W;                      // cross operand carrying m or e
   localparam int OPB_W  = AD_W;                     // cross operand carrying d or |d|
   localparam int XP_W   = OPA_W + OPB_W;            // one cross product
   localparam int SUM_W  = XP_W + 1;                 // sum or difference of two
   localparam int SPLIT  = 18;                       // partial-product cut of operand b

   localparam logic [REACH_W-1:0] REACH_ONE = REACH_W'(1) << REACH_BITS;

   // Register indexes on the csr channel
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Z  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON    = 3'd6;

   localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

   typedef logic [NUM_AXES-1:0][COORD_WIDTH-1:0] vec_type;

   typedef struct packed {
      vec_type          lo;
      vec_type          hi;
      logic [EPS_W-1:0] eps;
   } box_type;

   // Per-axis terms after the face test, operands already at cross widths
   typedef struct packed {
      logic                           valid;
      logic                           face_ok;
      logic [NUM_AXES-1:0][OPA_W-1:0] m;
      logic [NUM_AXES-1:0][OPA_W-1:0] e;
      logic [NUM_AXES-1:0][OPB_W-1:0] d;
      logic [NUM_AXES-1:0][OPB_W-1:0] ad;
   } axes_type;

endpackage

[rtl/core/segment_box_overlap_test_top.sv]
// Top level of the segment versus axis-aligned box overlap test.
// Depends on sbo_pkg, sbo_shorten, sbo_mul and sbo_cross.
//
// Usage:
//  - req channel: one beat is one segment (start, far point, reach fraction).
//    The far point is first pulled in to start + reach * (far - start).
//  - rsp channel: one beat per request, carrying rsp_hit (1 = overlap).
//  - csr channel: writes the box corners (index 0..5) and the epsilon term
//    (index 6); other indexes are dropped. Always ready. Write only while
//    the pipeline is empty.
//  - Throughput: one segment per cycle when not stalled, set by the seven-stage
//    pipeline (three shorten/face stages, two multiplier stages, sum and compare).
//  - Stall: the whole pipeline holds while rsp_valid is high and rsp_ready
//    low; req_ready drops in the same cycle, so nothing is lost or repeated.
//    A held result keeps the pipeline from advancing but bubbles still move
//    out as soon as the receiver takes the waiting beat.
//  - Reset (synchronous): clears every stage valid, box corners to zero,
//    epsilon to one.
module segment_box_overlap_test_top import sbo_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_z,
   input  logic        [REACH_W-1:0]     req_reach_fraction,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic        [CSR_IDX_W-1:0]   csr_index,
   input  logic        [COORD_WIDTH-1:0] csr_wdata
);

   box_type  box_ff, box_in;
   axes_type sbo_axes;
   vec_type  start_vec, far_vec;
   logic     pipe_en;
   logic     csr_write;

   // Advance every stage together unless a finished beat is waiting at the output
   assign pipe_en   = !rsp_valid || rsp_ready;
   assign req_ready = pipe_en;

   assign start_vec = {req_start_z, req_start_y, req_start_x};
   assign far_vec   = {req_end_z, req_end_y, req_end_x};

   // Configuration registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      box_in = box_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_BOX_MIN_X: box_in.lo[0] = csr_wdata;
            CSR_BOX_MIN_Y: box_in.lo[1] = csr_wdata;
            CSR_BOX_MIN_Z: box_in.lo[2] = csr_wdata;
            CSR_BOX_MAX_X: box_in.hi[0] = csr_wdata;
            CSR_BOX_MAX_Y: box_in.hi[1] = csr_wdata;
            CSR_BOX_MAX_Z: box_in.hi[2] = csr_wdata;
            CSR_EPSILON:   box_in.eps   = csr_wdata[EPS_W-1:0];
            default: ;   // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff.lo  <= '0;
         box_ff.hi  <= '0;
         box_ff.eps <= EPS_RESET;
      end else begin
         box_ff <= box_in;
      end
   end

   // Stages 1-3: shorten segment, per-axis terms, face-axis test
   sbo_shorten u_shorten (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (req_valid),
      .start    (start_vec),
      .far      (far_vec),
      .reach    (req_reach_fraction),
      .box      (box_ff),
      .axes     (sbo_axes)
   );

   // Stages 4-7: cross-product axes and the output register
   sbo_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .axes      (sbo_axes),
      .hit_valid (rsp_valid),
      .hit       (rsp_hit)
   );

   // The output is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // A stalled pipeline holds its middle stage
   a_stall_holds_mid: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(sbo_axes.valid) && $stable(sbo_axes.face_ok))
      else $error("middle stage moved while the output was stalled");

   // No req beat is taken while a result waits unclaimed
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
      else $error("req beat accepted during an output stall");

endmodule

[rtl/core/sbo_shorten.sv]
// Stages 1-3: shorten the segment, form e/d/m per axis and run the face-axis test.
// Depends on sbo_pkg.
module sbo_shorten import sbo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  vec_type            start,
   input  vec_type            far,
   input  logic [REACH_W-1:0] reach,
   input  box_type            box,
   output axes_type           axes
);

   // stage 1
   logic                     v1_ff, v1_in;
   logic signed [DIFF_W-1:0] diff_ff [NUM_AXES];
   logic signed [DIFF_W-1:0] diff_in [NUM_AXES];
   vec_type                  p1a_ff;
   logic [REACH_W-1:0]       reach_ff, reach_in;

   // stage 2
   logic                     v2_ff;
   logic signed [PROD_W-1:0] prod_ff [NUM_AXES];
   logic signed [PROD_W-1:0] prod_in [NUM_AXES];
   vec_type                  p1b_ff;

   // stage 3
   logic                           v3_ff;
   logic                           face_ok_ff, face_ok_in;
   logic [NUM_AXES-1:0][OPA_W-1:0] m_ff, m_in, e_ff, e_in;
   logic [NUM_AXES-1:0][OPB_W-1:0] d_ff, d_in, ad_ff, ad_in;

   assign v1_in = in_valid;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         diff_in[a] = DIFF_W'($signed(far[a])) - DIFF_W'($signed(start[a]));
      end
      reach_in = (reach > REACH_ONE) ? REACH_ONE : reach;
   end

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         prod_in[a] = diff_ff[a] * $signed({1'b0, reach_ff});
      end
   end

   always_comb begin
      logic signed [D_W-1:0]   d;
      logic signed [M_W-1:0]   m;
      logic signed [OPA_W-1:0] e;
      logic signed [AD_W-1:0]  ad;
      logic signed [CMP_W-1:0] mabs;
      logic signed [CMP_W-1:0] lim;
      face_ok_in = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
         // floor(reach * diff / 2^16): arithmetic shift of the exact product
         d = $signed(prod_ff[a][PROD_W-1:REACH_BITS]);
         e = OPA_W'($signed(box.hi[a])) - OPA_W'($signed(box.lo[a]));
         m = (M_W'($signed(p1b_ff[a])) <<< 1) + M_W'(d)
             - M_W'($signed(box.lo[a])) - M_W'($signed(box.hi[a]));
         ad = (d < 0) ? -AD_W'(d) : AD_W'(d);
         mabs = (m < 0) ? -CMP_W'(m) : CMP_W'(m);
         lim  = CMP_W'(e) + CMP_W'(ad);
         if (mabs > lim) begin
            face_ok_in = 1'b0;
         end
         m_in[a]  = OPA_W'(m);
         e_in[a]  = e;
         d_in[a]  = OPB_W'(d);
         ad_in[a] = ad + $signed(AD_W'(box.eps));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff    <= diff_in;
         p1a_ff     <= start;
         reach_ff   <= reach_in;
         prod_ff    <= prod_in;
         p1b_ff     <= p1a_ff;
         face_ok_ff <= face_ok_in;
         m_ff       <= m_in;
         e_ff       <= e_in;
         d_ff       <= d_in;
         ad_ff      <= ad_in;
      end
   end

   assign axes.valid   = v3_ff;
   assign axes.face_ok = face_ok_ff;
   assign axes.m       = m_ff;
   assign axes.e       = e_ff;
   assign axes.d       = d_ff;
   assign axes.ad      = ad_ff;

endmodule

[rtl/core/sbo_mul.sv]
// Two-stage signed multiplier: two registered partial products, then a registered sum.
// Depends on sbo_pkg.
module sbo_mul import sbo_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [OPA_W-1:0] a,
   input  logic [OPB_W-1:0] b,
   output logic [XP_W-1:0]  p
);

   localparam int PL_W = OPA_W + SPLIT + 1;
   localparam int PH_W = OPA_W + OPB_W - SPLIT;

   logic signed [PL_W-1:0] pl_ff, pl_in;
   logic signed [PH_W-1:0] ph_ff, ph_in;
   logic signed [XP_W-1:0] p_ff, p_in;

   // low slice of b is unsigned, high slice carries the sign
   assign pl_in = $signed(a) * $signed({1'b0, b[SPLIT-1:0]});
   assign ph_in = $signed(a) * $signed(b[OPB_W-1:SPLIT]);
   assign p_in  = (XP_W'(ph_ff) <<< SPLIT) + XP_W'(pl_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff <= pl_in;
         ph_ff <= ph_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

[rtl/core/sbo_cross.sv]
// Stages 4-7: cross-product axes (products, sum/difference, abs compare) and hit register.
// Depends on sbo_pkg and sbo_mul.
module sbo_cross import sbo_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  axes_type axes,
   output logic     hit_valid,
   output logic     hit
);

   logic [XP_W-1:0] xp_md [NUM_AXES];   // m[p]*d[q]
   logic [XP_W-1:0] xp_dm [NUM_AXES];   // m[q]*d[p]
   logic [XP_W-1:0] xp_ea [NUM_AXES];   // e[p]*ad[q]
   logic [XP_W-1:0] xp_ae [NUM_AXES];   // e[q]*ad[p]

   logic                    v4_ff, v5_ff, v6_ff, v7_ff;
   logic                    f4_ff, f5_ff, f6_ff;
   logic signed [SUM_W-1:0] lhs_ff [NUM_AXES];
   logic signed [SUM_W-1:0] lhs_in [NUM_AXES];
   logic signed [SUM_W-1:0] rhs_ff [NUM_AXES];
   logic signed [SUM_W-1:0] rhs_in [NUM_AXES];
   logic                    hit_ff, hit_in;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      localparam int P = (a + 1) % NUM_AXES;
      localparam int Q = (a + 2) % NUM_AXES;

      sbo_mul u_md (.clock(clock), .en(en), .a(axes.m[P]), .b(axes.d[Q]),  .p(xp_md[a]));
      sbo_mul u_dm (.clock(clock), .en(en), .a(axes.m[Q]), .b(axes.d[P]),  .p(xp_dm[a]));
      sbo_mul u_ea (.clock(clock), .en(en), .a(axes.e[P]), .b(axes.ad[Q]), .p(xp_ea[a]));
      sbo_mul u_ae (.clock(clock), .en(en), .a(axes.e[Q]), .b(axes.ad[P]), .p(xp_ae[a]));

      assign lhs_in[a] = SUM_W'($signed(xp_md[a])) - SUM_W'($signed(xp_dm[a]));
      assign rhs_in[a] = SUM_W'($signed(xp_ea[a])) + SUM_W'($signed(xp_ae[a]));
   end

   always_comb begin
      logic signed [SUM_W:0] mag;
      hit_in = f6_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         mag = (lhs_ff[a] < 0) ? -(SUM_W + 1)'(lhs_ff[a]) : (SUM_W + 1)'(lhs_ff[a]);
         if (mag > (SUM_W + 1)'(rhs_ff[a])) begin
            hit_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= axes.valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f4_ff  <= axes.face_ok;
         f5_ff  <= f4_ff;
         f6_ff  <= f5_ff;
         lhs_ff <= lhs_in;
         rhs_ff <= rhs_in;
         hit_ff <= hit_in;
      end
   end

   assign hit_valid = v7_ff;
   assign hit       = hit_ff;

endmodule

[sim/segment_box_overlap_test_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for segment_box_overlap_test_top: streams segments against
// programmed boxes and checks every hit bit against an exact wide-integer predictor.
// Depends on sbo_pkg and the RTL under rtl/core; reads no files.
module segment_box_overlap_test_top_test import sbo_pkg::*;;

   localparam int CLK_HALF      = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int DRAIN_CYCLES  = 10;      // pipeline is 7 deep; allow a little slack
   // Slowest correct run: ~1300 beats, each up to the longest source gap plus the
   // longest sink stall plus the pipeline latency, ends before CYCLE_LIMIT is reached.
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int MAX_REPORTS   = 100;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BEATS   = 150;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;   // no register behind it
   localparam longint ONE         = 64'sd65536;          // 1.0 in Q16.16
   localparam longint COORD_FLOOR = -(64'sd1 <<< 31);
   localparam longint COORD_CEIL  = (64'sd1 <<< 31) - 1;
   localparam logic [REACH_W-1:0] REACH_MAX = '1;
   localparam logic [EPS_W-1:0]   EPS_MAX   = '1;

   typedef logic signed [127:0] exact_type;

   typedef struct packed {
      vec_type              start;
      vec_type              far_pt;
      logic [REACH_W-1:0]   reach;
   } segment_type;

   typedef enum int {BOX_NORMAL, BOX_THIN, BOX_WIDE, BOX_INVERTED, BOX_POINT} box_shape_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [COORD_WIDTH-1:0] req_start_x, req_start_y, req_start_z;
   logic [COORD_WIDTH-1:0] req_end_x, req_end_y, req_end_z;
   logic [REACH_W-1:0]     req_reach_fraction;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_hit;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [COORD_WIDTH-1:0] csr_wdata;

   // Predictor's copy of the box registers
   vec_type                box_lo;
   vec_type                box_hi;
   logic [EPS_W-1:0]       box_eps;

   bit                     hits_due[$];      // hit bits still owed by the block, oldest first
   bit                     want_hit;
   int                     failures    = 0;
   int                     cycle_count = 0;
   bit                     no_idle     = 1'b0;   // force a stretch of full-rate traffic

   segment_box_overlap_test_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_x        (req_start_x),
      .req_start_y        (req_start_y),
      .req_start_z        (req_start_z),
      .req_end_x          (req_end_x),
      .req_end_y          (req_end_y),
      .req_end_z          (req_end_z),
      .req_reach_fraction (req_reach_fraction),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor: exact integer separating-axis test, nothing can wrap at
   // 128 bits (products stay below 2^72).
   // ------------------------------------------------------------------
   function automatic exact_type magnitude(input exact_type v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic bit predict_hit(input segment_type s);
      exact_type rch, p1, p2, lo, hi, epsw, lhs, rhs;
      exact_type d  [NUM_AXES];
      exact_type e  [NUM_AXES];
      exact_type m  [NUM_AXES];
      exact_type ad [NUM_AXES];
      int        p, q;
      bit        hit;
      hit  = 1'b1;
      // clamp reach above whole to exactly one
      rch  = (s.reach > REACH_ONE) ? REACH_ONE : s.reach;
      epsw = box_eps;
      for (int a = 0; a < NUM_AXES; a++) begin
         p1 = $signed(s.start[a]);
         p2 = $signed(s.far_pt[a]);
         lo = $signed(box_lo[a]);
         hi = $signed(box_hi[a]);
         // shorten with floor rounding (arithmetic shift of the exact product)
         d[a]  = (rch * (p2 - p1)) >>> REACH_BITS;
         e[a]  = hi - lo;
         m[a]  = 2 * p1 + d[a] - lo - hi;
         ad[a] = magnitude(d[a]);
         if (magnitude(m[a]) > e[a] + ad[a])
            hit = 1'b0;
      end
      if (hit) begin
         for (int a = 0; a < NUM_AXES; a++)
            ad[a] = ad[a] + epsw;
         // cross axes: (y,z), (z,x), (x,y)
         for (int a = 0; a < NUM_AXES; a++) begin
            p   = (a + 1) % NUM_AXES;
            q   = (a + 2) % NUM_AXES;
            lhs = magnitude(m[p] * d[q] - m[q] * d[p]);
            rhs = e[p] * ad[q] + e[q] * ad[p];
            if (lhs > rhs)
               hit = 1'b0;
         end
      end
      return hit;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] index,
                                     input logic [COORD_WIDTH-1:0] data);
      case (index)
         CSR_BOX_MIN_X: box_lo[0] = data;
         CSR_BOX_MIN_Y: box_lo[1] = data;
         CSR_BOX_MIN_Z: box_lo[2] = data;
         CSR_BOX_MAX_X: box_hi[0] = data;
         CSR_BOX_MAX_Y: box_hi[1] = data;
         CSR_BOX_MAX_Z: box_hi[2] = data;
         CSR_EPSILON:   box_eps   = data[EPS_W-1:0];
         default: ;     // unmapped index: dropped
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // Mostly no gap, some short, a few long.
   function automatic int pick_gap();
      int unsigned r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic vec_type axes(input longint x, input longint y, input longint z);
      vec_type v;
      v[0] = COORD_WIDTH'(x);
      v[1] = COORD_WIDTH'(y);
      v[2] = COORD_WIDTH'(z);
      return v;
   endfunction

   function automatic segment_type seg(input longint sx, input longint sy, input longint sz,
                                       input longint fx, input longint fy, input longint fz,
                                       input logic [REACH_W-1:0] reach);
      segment_type s;
      s.start  = axes(sx, sy, sz);
      s.far_pt = axes(fx, fy, fz);
      s.reach  = reach;
      return s;
   endfunction

   // Coordinate within one box width of either face, clamped to the Q16.16 range.
   function automatic logic [COORD_WIDTH-1:0] coord_near(input longint lo, input longint hi);
      longint     span, v;
      bit [63:0]  r;
      if (lo > hi) begin
         v  = lo;
         lo = hi;
         hi = v;
      end
      span = hi - lo + 1;
      r    = {$urandom(), $urandom()};
      v    = lo - span + longint'(r[61:0]) % (3 * span);
      if (v < COORD_FLOOR) v = COORD_FLOOR;
      if (v > COORD_CEIL)  v = COORD_CEIL;
      return COORD_WIDTH'(v);
   endfunction

   function automatic logic [REACH_W-1:0] random_reach();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6) return REACH_ONE;
      if (r < 8) return REACH_W'($urandom_range(0, REACH_ONE));
      if (r < 9) return REACH_W'($urandom_range(0, 1));
      return REACH_W'($urandom_range(REACH_ONE + 1, REACH_MAX));
   endfunction

   // Mostly segments around the box, some zero-length, some anywhere.
   function automatic segment_type random_segment();
      segment_type s;
      int unsigned kind;
      kind = $urandom_range(0, 99);
      for (int a = 0; a < NUM_AXES; a++) begin
         if (kind < 70) begin
            s.start[a]  = coord_near($signed(box_lo[a]), $signed(box_hi[a]));
            s.far_pt[a] = coord_near($signed(box_lo[a]), $signed(box_hi[a]));
         end else if (kind < 85) begin
            s.start[a]  = coord_near($signed(box_lo[a]), $signed(box_hi[a]));
            s.far_pt[a] = s.start[a];
         end else begin
            s.start[a]  = $urandom();
            s.far_pt[a] = $urandom();
         end
      end
      s.reach = random_reach();
      return s;
   endfunction

   // Send one segment beat. Valid stays high on return so a zero gap gives
   // back-to-back beats; the next caller lowers it if it idles.
   task automatic send_segment(input segment_type s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_start_x        <= s.start[0];
      req_start_y        <= s.start[1];
      req_start_z        <= s.start[2];
      req_end_x          <= s.far_pt[0];
      req_end_y          <= s.far_pt[1];
      req_end_z          <= s.far_pt[2];
      req_reach_fraction <= s.reach;
      do @(posedge clock); while (!req_ready);
      hits_due.push_back(predict_hit(s));
   endtask

   // Drop valid, wait for every owed beat, then let the pipeline settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (hits_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register; valid is left high so writes can go back to back.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [COORD_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(index, data);
   endtask

   task automatic load_box(input vec_type lo, input vec_type hi, input logic [EPS_W-1:0] eps);
      drain_results();
      for (int a = 0; a < NUM_AXES; a++) begin
         csr_write(CSR_IDX_W'(CSR_BOX_MIN_X + a), lo[a]);
         csr_write(CSR_IDX_W'(CSR_BOX_MAX_X + a), hi[a]);
      end
      // upper data bits are unused for epsilon; randomize them
      csr_write(CSR_EPSILON, {16'($urandom()), eps});
      csr_valid <= 1'b0;
   endtask

   task automatic random_box(input box_shape_type shape, input logic [EPS_W-1:0] eps);
      vec_type lo, hi;
      longint  c, h;
      for (int a = 0; a < NUM_AXES; a++) begin
         c = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
         h = (shape == BOX_WIDE) ? $urandom_range(0, 1 << 30) : $urandom_range(0, 1 << 18);
         if (shape == BOX_POINT || (shape == BOX_THIN && a == 0))
            h = 0;
         lo[a] = COORD_WIDTH'(c - h);
         hi[a] = COORD_WIDTH'(c + h);
         if (shape == BOX_INVERTED && a == 1) begin
            lo[a] = COORD_WIDTH'(c + h + 1);
            hi[a] = COORD_WIDTH'(c - h);
         end
      end
      load_box(lo, hi, eps);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Reset box is a single point at the origin with epsilon one.
   task automatic test_reset_state();
      send_segment(seg(0, 0, 0, 0, 0, 0, REACH_ONE));
      send_segment(seg(1, 0, 0, 1, 0, 0, REACH_ONE));
      send_segment(seg(-ONE, 0, 0, ONE, 0, 0, REACH_ONE));
      send_segment(seg(-ONE, 1, 0, ONE, 1, 0, REACH_ONE));
   endtask

   // Unit box [-1,1]^3: boundaries, shortening, reach saturation, cross axes, extremes.
   task automatic test_unit_box();
      load_box(axes(-ONE, -ONE, -ONE), axes(ONE, ONE, ONE), EPS_RESET);
      send_segment(seg(0, 0, 0, 0, 0, 0, REACH_ONE));
      send_segment(seg(ONE, ONE, ONE, ONE, ONE, ONE, REACH_ONE));      // corner counts inside
      send_segment(seg(ONE + 1, 0, 0, ONE + 1, 0, 0, REACH_ONE));      // one LSB outside
      send_segment(seg(-3 * ONE, 0, 0, 3 * ONE, 0, 0, REACH_ONE));
      send_segment(seg(-3 * ONE, 0, 0, 3 * ONE, 0, 0, 17'h04000));     // cut short of the box
      send_segment(seg(-3 * ONE, 0, 0, 3 * ONE, 0, 0, '0));            // reach zero, outside
      send_segment(seg(0, 0, 0, 3 * ONE, 3 * ONE, 3 * ONE, '0));       // reach zero, inside
      // far point two LSB short of the face: only an unclamped reach would touch it
      send_segment(seg(-3 * ONE, 0, 0, -ONE - 2, 0, 0, REACH_ONE + 1));
      send_segment(seg(-3 * ONE, 0, 0, -ONE - 2, 0, 0, REACH_MAX));
      // diagonal past the corner: face axes overlap, a cross axis separates
      send_segment(seg(0, 3 * ONE, 0, 3 * ONE, 0, 0, REACH_ONE));
      send_segment(seg(0, 124518, 0, 124518, 0, 0, REACH_ONE));
      send_segment(seg(COORD_FLOOR, COORD_FLOOR, COORD_FLOOR,
                       COORD_CEIL, COORD_CEIL, COORD_CEIL, REACH_ONE));
      send_segment(seg(COORD_CEIL, COORD_CEIL, COORD_CEIL,
                       COORD_CEIL, COORD_CEIL, COORD_CEIL, REACH_ONE));
      send_segment(seg(COORD_FLOOR, COORD_FLOOR, COORD_FLOOR,
                       COORD_FLOOR, COORD_FLOOR, COORD_FLOOR, REACH_ONE));
      send_segment(seg(COORD_CEIL, COORD_FLOOR, COORD_CEIL,
                       COORD_FLOOR, COORD_CEIL, COORD_FLOOR, REACH_MAX));
   endtask

   // Min above max on every axis, then a zero-size box with zero epsilon.
   task automatic test_inverted_box();
      load_box(axes(ONE, ONE, ONE), axes(-ONE, -ONE, -ONE), EPS_RESET);
      send_segment(seg(0, 0, 0, 0, 0, 0, REACH_ONE));
      send_segment(seg(-3 * ONE, 0, 0, 3 * ONE, 0, 0, REACH_ONE));
      load_box(axes(0, 0, 0), axes(0, 0, 0), '0);
      send_segment(seg(0, 0, 0, 0, 0, 0, REACH_ONE));
      send_segment(seg(0, 1, 0, 0, 1, 0, REACH_ONE));
   endtask

   // Box spanning the whole coordinate range, largest and zero epsilon.
   task automatic test_extreme_box();
      load_box(axes(COORD_FLOOR, COORD_FLOOR, COORD_FLOOR),
               axes(COORD_CEIL, COORD_CEIL, COORD_CEIL), EPS_MAX);
      send_segment(seg(COORD_FLOOR, COORD_FLOOR, COORD_FLOOR,
                       COORD_FLOOR, COORD_FLOOR, COORD_FLOOR, REACH_ONE));
      send_segment(seg(COORD_CEIL, COORD_CEIL, COORD_CEIL,
                       COORD_FLOOR, COORD_FLOOR, COORD_FLOOR, REACH_ONE));
      send_segment(random_segment());
      load_box(axes(COORD_FLOOR, COORD_FLOOR, COORD_FLOOR),
               axes(COORD_CEIL, COORD_CEIL, COORD_CEIL), '0);
      send_segment(random_segment());
   endtask

   // A write to the unmapped index must leave the box untouched.
   task automatic test_unknown_index();
      drain_results();
      csr_write(CSR_UNUSED, $urandom());
      csr_valid <= 1'b0;
      repeat (4) send_segment(random_segment());
   endtask

   // Random segments around a fresh box each phase; one phase runs at full rate.
   task automatic test_random_phases();
      logic [EPS_W-1:0] eps;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)      eps = '0;
         else if (phase == 1) eps = EPS_MAX;
         else                 eps = EPS_W'($urandom_range(0, EPS_MAX));
         random_box(box_shape_type'(phase % 5), eps);
         no_idle = (phase == 2);
         repeat (PHASE_BEATS) send_segment(random_segment());
         no_idle = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------
   // Result sink: random stalls, long ready runs in between.
   // ------------------------------------------------------------------
   initial begin : rsp_sink
      int run;
      forever begin
         rsp_ready <= 1'b1;
         run = $urandom_range(1, 40);
         repeat (run) @(posedge clock);
         run = pick_gap();
         if (run > 0) begin
            rsp_ready <= 1'b0;
            repeat (run) @(posedge clock);
         end
      end
   end

   // Compare each result beat against the oldest owed hit bit.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (hits_due.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: unexpected result beat, expected none actual hit=%0b",
                        $time, rsp_hit);
         end else begin
            want_hit = hits_due.pop_front();
            if (rsp_hit !== want_hit) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("%0t: hit mismatch, expected %0b actual %0b",
                           $time, want_hit, rsp_hit);
            end
         end
      end
   end

   // Watchdog: end the run if the block hangs.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      // hold every input at a known value through reset
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_start_x        = '0;
      req_start_y        = '0;
      req_start_z        = '0;
      req_end_x          = '0;
      req_end_y          = '0;
      req_end_z          = '0;
      req_reach_fraction = '0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      box_lo             = '0;
      box_hi             = '0;
      box_eps            = EPS_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_unit_box();
      test_inverted_box();
      test_extreme_box();
      test_unknown_index();
      test_random_phases();

      drain_results();
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[files.f]
rtl/core/sbo_pkg.sv
rtl/core/sbo_shorten.sv
rtl/core/sbo_mul.sv
rtl/core/sbo_cross.sv
rtl/core/segment_box_overlap_test_top.sv
sim/segment_box_overlap_test_top_test.sv
